/* rtl/psra_pkg.sv */
package psra_pkg;

   // Field widths of one transaction
   localparam int COUNT_W     = 10;
   localparam int WORD_W      = 64;
   localparam int REQ_TDATA_W = 208;
   localparam int RSP_TDATA_W = 128;

   // Configuration port geometry: 64-bit registers at byte address 8*i
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // Register indexes (paddr[5:3])
   localparam logic [2:0] REG_MAP_BASE     = 3'd0;
   localparam logic [2:0] REG_WINDOW_FIRST = 3'd1;
   localparam logic [2:0] REG_WINDOW_END   = 3'd2;
   localparam logic [2:0] REG_PAGE_SHIFT   = 3'd3;
   localparam logic [2:0] REG_FRAME_MASK   = 3'd4;

   // Register reset values
   localparam logic [63:0] MAP_BASE_RST     = 64'h0;
   localparam logic [8:0]  WINDOW_FIRST_RST = 9'd0;
   localparam logic [9:0]  WINDOW_END_RST   = 10'd512;
   localparam logic [4:0]  PAGE_SHIFT_RST   = 5'd12;
   localparam logic [63:0] FRAME_MASK_RST   = 64'h000F_FFFF_FFFF_F000;

   // Operation and status codes
   localparam logic OP_MAP      = 1'b0;
   localparam logic OP_UNMAP    = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // Present flag position within a table entry
   localparam int PRESENT_BIT = 0;

   typedef struct packed {
      logic [63:0] map_base;
      logic [8:0]  window_first;
      logic [9:0]  window_end;
      logic [4:0]  page_shift;
      logic [63:0] frame_mask;
   } cfg_type;

endpackage

/* rtl/psra_ram.sv */
module psra_ram
   import psra_pkg::*;
#(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Read-first: a read and a write to the same entry return the old data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/psra_csr.sv */
module psra_csr
   import psra_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index  = paddr[5:3];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   // Update the addressed register on a write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_MAP_BASE:     cfg_in.map_base     = pwdata;
            REG_WINDOW_FIRST: cfg_in.window_first = pwdata[8:0];
            REG_WINDOW_END:   cfg_in.window_end   = pwdata[9:0];
            REG_PAGE_SHIFT:   cfg_in.page_shift   = pwdata[4:0];
            REG_FRAME_MASK:   cfg_in.frame_mask   = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_base     <= MAP_BASE_RST;
         cfg_ff.window_first <= WINDOW_FIRST_RST;
         cfg_ff.window_end   <= WINDOW_END_RST;
         cfg_ff.page_shift   <= PAGE_SHIFT_RST;
         cfg_ff.frame_mask   <= FRAME_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (index)
         REG_MAP_BASE:     prdata = cfg_ff.map_base;
         REG_WINDOW_FIRST: prdata = 64'(cfg_ff.window_first);
         REG_WINDOW_END:   prdata = 64'(cfg_ff.window_end);
         REG_PAGE_SHIFT:   prdata = 64'(cfg_ff.page_shift);
         REG_FRAME_MASK:   prdata = cfg_ff.frame_mask;
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/psra_urem.sv */
module psra_urem
   import psra_pkg::*;
#(
   parameter int MODULUS = 512,
   parameter int DATA_W  = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DATA_W-1:0]          value,
   output logic                       done,
   output logic [$clog2(MODULUS)-1:0] rem
);

   localparam int RW      = $clog2(MODULUS);
   localparam int CHUNK_W = 16;
   localparam int NCHUNK  = DATA_W / CHUNK_W;
   localparam int XW      = RW + CHUNK_W;
   localparam int PW      = XW + 32;
   localparam int SW      = $clog2(NCHUNK);
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MODULUS));

   logic [DATA_W-1:0] val_ff, val_in;
   logic [RW-1:0]     rem_ff, rem_in;
   logic [XW-1:0]     x_ff, x_in;
   logic [XW-1:0]     q_ff, q_in;
   logic [SW-1:0]     step_ff, step_in;
   logic              phase_ff, phase_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [XW-1:0]     x_c;
   logic [PW-1:0]     prod;
   logic [XW-1:0]     diff;

   // Fold in one chunk per pass of two phases, most significant chunk first:
   // estimate the quotient by reciprocal, then subtract and correct once
   always_comb begin
      val_in   = val_ff;
      rem_in   = rem_ff;
      x_in     = x_ff;
      q_in     = q_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      x_c      = {rem_ff, val_ff[DATA_W-1 -: CHUNK_W]};
      prod     = PW'(x_c) * PW'(RECIP);
      diff     = x_ff - XW'(q_ff * XW'(MODULUS));
      if (diff >= XW'(MODULUS)) begin
         diff = diff - XW'(MODULUS);
      end
      if (start) begin
         val_in   = value;
         rem_in   = '0;
         step_in  = '0;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            x_in     = x_c;
            q_in     = prod[PW-1:32];
            val_in   = {val_ff[DATA_W-CHUNK_W-1:0], CHUNK_W'(0)};
            phase_in = 1'b1;
         end else begin
            rem_in   = diff[RW-1:0];
            step_in  = step_ff + 1'b1;
            phase_in = 1'b0;
            if (step_ff == SW'(NCHUNK - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      rem_ff   <= rem_in;
      x_ff     <= x_in;
      q_ff     <= q_in;
      step_ff  <= step_in;
      phase_ff <= phase_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

/* rtl/page_slot_run_allocator.sv */
// A map scans the window for a free run and writes it; a zero count or an empty window
// fails without a scan. An unmap clears entries from the remainder index.
// One transaction is in work at a time: the next request is
// taken the cycle after the response is loaded, even while that response is stalled.
// Reset: control and configuration registers take their defaults at once; a clearing
// pass then zeroes the table, with req_tready low (configuration writes are still taken).
module page_slot_run_allocator
   import psra_pkg::*;
#(
   parameter int TABLE_ENTRIES = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // frame[63:0], flags[127:64], count[137:128],
                                              // virt_addr[201:138], zero pad
   input  logic                   req_tuser,  // operation
   // response
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // mapped_addr[63:0], first_frame[127:64]
   output logic                   rsp_tuser,  // status
   // configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_UMOD  = 3'd5;
   localparam logic [2:0] S_CLEAR = 3'd6;
   localparam logic [2:0] S_RESP  = 3'd7;

   cfg_type cfg;

   // control state
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      init_addr_ff, init_addr_in;
   logic               pend_ff, pend_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   // transaction payload
   logic               op_ff, op_in;
   logic [WORD_W-1:0]  frame_ff, frame_in;
   logic [WORD_W-1:0]  flags_ff, flags_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  virt_ff, virt_in;
   logic [CW-1:0]      cur_ff, cur_in;
   logic [CW-1:0]      pend_idx_ff, pend_idx_in;
   logic [CW-1:0]      run_start_ff, run_start_in;
   logic [CW-1:0]      run_len_ff, run_len_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [WORD_W-1:0]  first_ff, first_in;
   logic               res_status_ff, res_status_in;
   logic [WORD_W-1:0]  res_mapped_ff, res_mapped_in;
   logic               rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]  rsp_mapped_ff, rsp_mapped_in;
   logic [WORD_W-1:0]  rsp_first_ff, rsp_first_in;

   // table RAM and remainder unit
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic [AW-1:0]      mem_raddr;
   logic [WORD_W-1:0]  mem_rdata;
   logic               urem_start;
   logic [WORD_W-1:0]  urem_value;
   logic               urem_done;
   logic [AW-1:0]      urem_rem;

   logic [CW-1:0]      hi_c;
   logic               clr_issue;

   psra_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   psra_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   psra_urem #(
      .MODULUS (TABLE_ENTRIES),
      .DATA_W  (WORD_W)
   ) u_urem (
      .clock (clock),
      .reset (reset),
      .start (urem_start),
      .value (urem_value),
      .done  (urem_done),
      .rem   (urem_rem)
   );

   // Clamp the window end to the table
   assign hi_c = (32'(cfg.window_end) >= 32'(TABLE_ENTRIES)) ?
                 CW'(TABLE_ENTRIES) : CW'(cfg.window_end);

   assign clr_issue = (left_ff != '0) && (32'(cur_ff) < 32'(TABLE_ENTRIES));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_first_ff, rsp_mapped_ff};

   // Sequencer: clear, scan, write back, unmap
   always_comb begin
      state_in      = state_ff;
      init_addr_in  = init_addr_ff;
      pend_in       = pend_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      op_in         = op_ff;
      frame_in      = frame_ff;
      flags_in      = flags_ff;
      count_in      = count_ff;
      virt_in       = virt_ff;
      cur_in        = cur_ff;
      pend_idx_in   = pend_idx_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      hi_in         = hi_ff;
      left_in       = left_ff;
      first_in      = first_ff;
      res_status_in = res_status_ff;
      res_mapped_in = res_mapped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_first_in  = rsp_first_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_raddr     = '0;
      urem_start    = 1'b0;
      urem_value    = virt_ff >> cfg.page_shift;

      // Drop the response once taken
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            mem_we       = 1'b1;
            mem_waddr    = init_addr_ff;
            init_addr_in = init_addr_ff + 1'b1;
            if (init_addr_ff == AW'(TABLE_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               frame_in = req_tdata[63:0];
               flags_in = req_tdata[127:64];
               count_in = req_tdata[137:128];
               virt_in  = req_tdata[201:138];
               state_in = S_START;
            end
         end

         S_START: begin
            res_status_in = STATUS_OK;
            res_mapped_in = '0;
            first_in      = '0;
            pend_in       = 1'b0;
            if (op_ff == OP_MAP) begin
               if ((count_ff == '0) || (32'(cfg.window_first) >= 32'(hi_c))) begin
                  res_status_in = STATUS_FAIL;
                  state_in      = S_RESP;
               end else begin
                  hi_in        = hi_c;
                  cur_in       = CW'(cfg.window_first);
                  run_start_in = CW'(cfg.window_first);
                  run_len_in   = '0;
                  state_in     = S_SCAN;
               end
            end else begin
               urem_start = 1'b1;
               state_in   = S_UMOD;
            end
         end

         S_SCAN: begin
            // Issue one read a cycle across the window
            if (cur_ff < hi_ff) begin
               mem_raddr   = cur_ff[AW-1:0];
               cur_in      = cur_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = cur_ff;
            end else begin
               pend_in = 1'b0;
            end
            // Track the current run of free entries
            if (pend_ff) begin
               if (mem_rdata[PRESENT_BIT]) begin
                  run_start_in = pend_idx_ff + 1'b1;
                  run_len_in   = '0;
               end else if (32'(run_len_ff) + 32'd1 == 32'(count_ff)) begin
                  cur_in   = run_start_ff;
                  left_in  = count_ff;
                  pend_in  = 1'b0;
                  state_in = S_WRITE;
               end else begin
                  run_len_in = run_len_ff + 1'b1;
               end
            end else if (cur_ff >= hi_ff) begin
               res_status_in = STATUS_FAIL;
               state_in      = S_RESP;
            end
         end

         S_WRITE: begin
            mem_we        = 1'b1;
            mem_waddr     = cur_ff[AW-1:0];
            mem_wdata     = frame_ff | flags_ff;
            frame_in      = frame_ff + (64'(1) << cfg.page_shift);
            cur_in        = cur_ff + 1'b1;
            left_in       = left_ff - 1'b1;
            res_mapped_in = cfg.map_base + (64'(run_start_ff) << cfg.page_shift);
            if (left_ff == COUNT_W'(1)) begin
               state_in = S_RESP;
            end
         end

         S_UMOD: begin
            if (urem_done) begin
               cur_in   = CW'(urem_rem);
               left_in  = count_ff;
               state_in = S_CLEAR;
            end
         end

         S_CLEAR: begin
            // Read and zero the same entry; the old value returns next cycle
            if (clr_issue) begin
               mem_raddr = cur_ff[AW-1:0];
               mem_we    = 1'b1;
               mem_waddr = cur_ff[AW-1:0];
               cur_in    = cur_ff + 1'b1;
               left_in   = left_ff - 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && (first_ff == '0)) begin
               first_in = mem_rdata & cfg.frame_mask;
            end
            if (!pend_ff && !clr_issue) begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            // Hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_mapped_in = res_mapped_ff;
               rsp_first_in  = first_ff;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_addr_ff  <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_addr_ff  <= init_addr_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      frame_ff      <= frame_in;
      flags_ff      <= flags_in;
      count_ff      <= count_in;
      virt_ff       <= virt_in;
      cur_ff        <= cur_in;
      pend_idx_ff   <= pend_idx_in;
      run_start_ff  <= run_start_in;
      run_len_ff    <= run_len_in;
      hi_ff         <= hi_in;
      left_ff       <= left_in;
      first_ff      <= first_in;
      res_status_ff <= res_status_in;
      res_mapped_ff <= res_mapped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_first_ff  <= rsp_first_in;
   end

   // A new response appears only as the sequencer leaves its response state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(state_ff) == S_RESP))
      else $error("response raised outside the response state");

   // Every table write stays inside the table
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(mem_waddr) < 32'(TABLE_ENTRIES)))
      else $error("table write beyond the last entry");

   // The remainder unit finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      urem_done |-> (state_ff == S_UMOD))
      else $error("remainder result arrived outside the unmap wait");

   // An accepted request always enters the decode step next
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_START))
      else $error("accepted request not decoded");

endmodule
